[src/active_transaction_watermark_queue_unit_assert.svh]
// Assertion macros for the checker of the watermark queue.
// Depends on nothing; included by the checker module.
`ifndef ACTIVE_TRANSACTION_WATERMARK_QUEUE_UNIT_ASSERT_SVH
`define ACTIVE_TRANSACTION_WATERMARK_QUEUE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ATWQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ATWQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[src/atwq_pkg.sv]
// Package of the watermark queue: action and status codes, controller states.
// Depends on nothing.
`default_nettype none
package atwq_pkg;
   typedef enum logic [2:0] {
      ACT_ACTIVATE_TX  = 3'd0,
      ACT_DEACT_TX     = 3'd1,
      ACT_ACTIVATE_IDX = 3'd2,
      ACT_DEACT_IDX    = 3'd3,
      ACT_CLEAR        = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_ORDER  = 3'd1,
      ST_NO_ID  = 3'd2,
      ST_NO_IDX = 3'd3,
      ST_FULL   = 3'd4,
      ST_DUP    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MSCAN,     // table scan, one entry per cycle
      S_MWAIT,     // last table read in flight
      S_TAILRD,    // read tail index
      S_TAILCHK,
      S_QSCAN,     // queue search
      S_QWAIT,
      S_POPRD,     // read head entry
      S_POPCHK,
      S_HEADRD,    // read head index for the result
      S_HEADCHK,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

[src/active_transaction_watermark_queue_unit.sv]
// Watermark queue top level: queue and id table in synchronous memories; uses atwq_pkg.
// Timing is set by the one-entry-per-cycle table scan over all MAP_ENTRIES and by the
// queue search (S_QSCAN, S_QWAIT) and head pop (S_POPRD, S_POPCHK) steps.
// Throughput: one transaction at a time, next accepted in the cycle after the result is taken.
// Reset: head, count, table valid bits and controller cleared; memory contents are not
// cleared, and data read outside the occupied window or valid entries is ignored.
`default_nettype none
module active_transaction_watermark_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned MAP_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [63:0] req_trans_id,
   input  wire logic [63:0] req_log_idx,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic             rsp_release_valid,
   output logic [63:0]      rsp_release_index
);
   localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned MW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned NW = $clog2(MAP_ENTRIES + 1);
   localparam int unsigned SW = CW + QW + 1;

   // memories
   logic [63:0] q_idx_mem [QUEUE_DEPTH];
   logic        q_inact_mem [QUEUE_DEPTH];
   logic [63:0] m_id_mem [MAP_ENTRIES];
   logic [63:0] m_start_mem [MAP_ENTRIES];
   logic [MAP_ENTRIES-1:0] m_valid_ff, m_valid_in;

   atwq_pkg::state_type state_ff, state_in;
   logic [QW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    act_ff, act_in;
   logic [63:0]   id_ff, id_in, key_ff, key_in;
   logic [2:0]    st_ff, st_in;
   logic [NW-1:0] mptr_ff, mptr_in;      // table scan pointer
   logic [CW-1:0] qoff_ff, qoff_in;      // queue scan offset
   logic          mhit_ff, mhit_in, mfree_ok_ff, mfree_ok_in;
   logic [MW-1:0] mhit_sel_ff, mhit_sel_in, mfree_ff, mfree_in;
   logic [QW-1:0] qslot_ff;

   // memory read ports (registered data)
   logic [QW-1:0] q_raddr;
   logic [MW-1:0] m_raddr;
   logic [63:0]   q_rdata_ff, m_id_rdata_ff, m_start_rdata_ff;
   logic          q_inact_rdata_ff;
   logic [MW-1:0] m_rtag_ff;             // address of table data in flight
   logic          m_rvalid_ff;
   // write controls
   logic          q_we, qi_we, m_we;
   logic [QW-1:0] q_waddr, qi_waddr;
   logic [63:0]   q_wdata;
   logic          qi_wdata;

   logic          rsp_valid_ff, rsp_rv_ff;
   logic [2:0]    rsp_st_ff;
   logic [63:0]   rsp_ri_ff;
   logic          rsp_load;
   logic [63:0]   rsp_ri_in;

   function automatic logic [QW-1:0] slot_add(input logic [QW-1:0] h,
                                              input logic [CW-1:0] o);
      logic [SW-1:0] s;
      s = {{(CW+1){1'b0}}, h} + {{(QW+1){1'b0}}, o};
      // sum stays below two laps, one conditional subtract wraps it
      if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
      return s[QW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (q_we) q_idx_mem[q_waddr] <= q_wdata;
      if (qi_we) q_inact_mem[qi_waddr] <= qi_wdata;
      if (m_we) begin
         m_id_mem[mfree_ff] <= id_ff;
         m_start_mem[mfree_ff] <= key_ff;
      end
      q_rdata_ff <= q_idx_mem[q_raddr];
      q_inact_rdata_ff <= q_inact_mem[q_raddr];
      m_id_rdata_ff <= m_id_mem[m_raddr];
      m_start_rdata_ff <= m_start_mem[m_raddr];
   end

   assign req_ready = (state_ff == atwq_pkg::S_IDLE) && !rsp_valid_ff;
   wire req_take = req_valid && req_ready;
   wire [CW-1:0] tail_off = count_ff - CW'(1);
   wire m_tag_hit = m_valid_ff[m_rtag_ff] && (m_id_rdata_ff == id_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atwq_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_action == atwq_pkg::ACT_ACTIVATE_TX ||
                   req_action == atwq_pkg::ACT_DEACT_TX)
                  state_in = atwq_pkg::S_MSCAN;
               else if (req_action == atwq_pkg::ACT_ACTIVATE_IDX)
                  state_in = atwq_pkg::S_TAILRD;
               else if (req_action == atwq_pkg::ACT_DEACT_IDX)
                  state_in = atwq_pkg::S_QSCAN;
               else
                  state_in = atwq_pkg::S_HEADRD;
            end
         end
         atwq_pkg::S_MSCAN:
            if (mptr_ff == NW'(MAP_ENTRIES - 1)) state_in = atwq_pkg::S_MWAIT;
         atwq_pkg::S_MWAIT: begin
            if (mhit_in) begin
               state_in = (act_ff == atwq_pkg::ACT_ACTIVATE_TX) ?
                          atwq_pkg::S_HEADRD : atwq_pkg::S_QSCAN;
            end else begin
               state_in = (act_ff == atwq_pkg::ACT_ACTIVATE_TX) ?
                          atwq_pkg::S_TAILRD : atwq_pkg::S_HEADRD;
            end
         end
         atwq_pkg::S_TAILRD: state_in = atwq_pkg::S_TAILCHK;
         atwq_pkg::S_TAILCHK: state_in = atwq_pkg::S_HEADRD;
         atwq_pkg::S_QSCAN:
            state_in = (qoff_ff == count_ff) ? atwq_pkg::S_HEADRD : atwq_pkg::S_QWAIT;
         atwq_pkg::S_QWAIT:
            state_in = (q_rdata_ff == key_ff) ? atwq_pkg::S_POPRD : atwq_pkg::S_QSCAN;
         atwq_pkg::S_POPRD:
            state_in = (count_ff == '0) ? atwq_pkg::S_HEADRD : atwq_pkg::S_POPCHK;
         atwq_pkg::S_POPCHK:
            state_in = q_inact_rdata_ff ? atwq_pkg::S_POPRD : atwq_pkg::S_HEADRD;
         atwq_pkg::S_HEADRD: state_in = atwq_pkg::S_HEADCHK;
         atwq_pkg::S_HEADCHK: state_in = atwq_pkg::S_DONE;
         atwq_pkg::S_DONE: state_in = atwq_pkg::S_IDLE;
         default: state_in = atwq_pkg::S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      head_in = head_ff; count_in = count_ff; act_in = act_ff; id_in = id_ff;
      key_in = key_ff; st_in = st_ff; mptr_in = mptr_ff; qoff_in = qoff_ff;
      mhit_in = mhit_ff; mhit_sel_in = mhit_sel_ff; mfree_in = mfree_ff;
      mfree_ok_in = mfree_ok_ff; m_valid_in = m_valid_ff;
      q_raddr = head_ff; m_raddr = mptr_ff[MW-1:0];
      q_we = 1'b0; qi_we = 1'b0; m_we = 1'b0;
      q_waddr = slot_add(head_ff, count_ff); q_wdata = key_ff;
      qi_waddr = qslot_ff; qi_wdata = 1'b1;
      rsp_load = 1'b0; rsp_ri_in = '0;
      // table compare on data returned from the previous read
      if (m_rvalid_ff) begin
         if (m_tag_hit && !mhit_ff) begin
            mhit_in = 1'b1; mhit_sel_in = m_rtag_ff;
            if (act_ff == atwq_pkg::ACT_DEACT_TX) key_in = m_start_rdata_ff;
         end
      end
      unique case (state_ff)
         atwq_pkg::S_IDLE: begin
            act_in = req_action; id_in = req_trans_id; key_in = req_log_idx;
            st_in = atwq_pkg::ST_OK; mptr_in = '0; qoff_in = '0;
            mhit_in = 1'b0; mfree_ok_in = 1'b0;
            if (req_take && req_action == atwq_pkg::ACT_CLEAR) begin
               m_valid_in = '0; head_in = '0; count_in = '0;
            end
         end
         atwq_pkg::S_MSCAN: begin
            if (!m_valid_ff[mptr_ff[MW-1:0]] && !mfree_ok_ff) begin
               mfree_ok_in = 1'b1; mfree_in = mptr_ff[MW-1:0];
            end
            mptr_in = mptr_ff + NW'(1);
         end
         atwq_pkg::S_MWAIT: begin
            if (act_ff == atwq_pkg::ACT_ACTIVATE_TX) begin
               if (mhit_in) st_in = atwq_pkg::ST_DUP;
            end else if (!mhit_in) begin
               st_in = atwq_pkg::ST_NO_ID;
            end
         end
         atwq_pkg::S_TAILRD: q_raddr = slot_add(head_ff, tail_off);
         atwq_pkg::S_TAILCHK: begin
            if (count_ff != '0 && key_ff <= q_rdata_ff)
               st_in = atwq_pkg::ST_ORDER;
            else if (count_ff == CW'(QUEUE_DEPTH))
               st_in = atwq_pkg::ST_FULL;
            else if (act_ff == atwq_pkg::ACT_ACTIVATE_TX && !mfree_ok_ff)
               st_in = atwq_pkg::ST_FULL;
            else begin
               q_we = 1'b1; qi_we = 1'b1;
               qi_waddr = slot_add(head_ff, count_ff); qi_wdata = 1'b0;
               count_in = count_ff + CW'(1);
               if (act_ff == atwq_pkg::ACT_ACTIVATE_TX) begin
                  m_we = 1'b1; m_valid_in[mfree_ff] = 1'b1;
               end
            end
         end
         atwq_pkg::S_QSCAN: begin
            q_raddr = slot_add(head_ff, qoff_ff);
            if (qoff_ff == count_ff) st_in = atwq_pkg::ST_NO_IDX;
            else qoff_in = qoff_ff + CW'(1);
         end
         atwq_pkg::S_QWAIT: begin
            if (q_rdata_ff == key_ff) begin
               qi_we = 1'b1;
               if (act_ff == atwq_pkg::ACT_DEACT_TX) m_valid_in[mhit_sel_ff] = 1'b0;
            end
         end
         atwq_pkg::S_POPRD: q_raddr = head_ff;
         atwq_pkg::S_POPCHK: begin
            if (q_inact_rdata_ff) begin
               head_in = slot_add(head_ff, CW'(1)); count_in = count_ff - CW'(1);
            end
         end
         atwq_pkg::S_HEADRD: q_raddr = head_ff;
         atwq_pkg::S_HEADCHK: begin
            rsp_load = 1'b1;
            if (count_ff != '0)
               rsp_ri_in = (q_rdata_ff == '0) ? '0 : q_rdata_ff - 64'd1;
         end
         atwq_pkg::S_DONE: ;
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atwq_pkg::S_IDLE;
         head_ff <= '0; count_ff <= '0; m_valid_ff <= '0;
         rsp_valid_ff <= 1'b0; m_rvalid_ff <= 1'b0; mhit_ff <= 1'b0;
         mfree_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; count_ff <= count_in; m_valid_ff <= m_valid_in;
         mhit_ff <= mhit_in; mfree_ok_ff <= mfree_ok_in;
         m_rvalid_ff <= (state_ff == atwq_pkg::S_MSCAN);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      act_ff <= act_in; id_ff <= id_in; key_ff <= key_in; st_ff <= st_in;
      mptr_ff <= mptr_in; qoff_ff <= qoff_in; mhit_sel_ff <= mhit_sel_in;
      mfree_ff <= mfree_in; m_rtag_ff <= m_raddr;
      if (state_ff == atwq_pkg::S_QSCAN) qslot_ff <= q_raddr;
      if (rsp_load) begin
         rsp_st_ff <= st_ff; rsp_rv_ff <= (count_ff != '0); rsp_ri_ff <= rsp_ri_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_release_valid = rsp_rv_ff;
   assign rsp_release_index = rsp_ri_ff;
endmodule
`default_nettype wire

[src/atwq_checker.sv]
// Port checker for the watermark queue, bound to the top level.
// Depends on active_transaction_watermark_queue_unit_assert.svh.
`default_nettype none
`include "active_transaction_watermark_queue_unit_assert.svh"
module atwq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_release_valid,
   input wire logic [63:0] rsp_release_index
);
   `ATWQ_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_status <= 3'd5, "bad status")
   `ATWQ_ASSERT_IMP(a_idx_zero, clock, reset, rsp_valid && !rsp_release_valid, rsp_release_index == 64'd0, "index without valid")
   `ATWQ_ASSERT_NEXT(a_one_at_time, clock, reset, req_valid && req_ready, !req_ready, "second transaction taken")
   `ATWQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped")
endmodule
bind active_transaction_watermark_queue_unit atwq_checker u_atwq_checker (.*);
`default_nettype wire

[sim/active_transaction_watermark_queue_unit_tb.sv]
// Testbench of the watermark queue: directed table then random transactions,
// each response checked against a typed expectation or a behavioral model of queue and id table.
// Depends on atwq_pkg and active_transaction_watermark_queue_unit.
`default_nettype none
module active_transaction_watermark_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = 16;
   localparam int MDEPTH = 16;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic [63:0] req_trans_id = '0;
   logic [63:0] req_log_idx = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic rsp_release_valid;
   logic [63:0] rsp_release_index;

   active_transaction_watermark_queue_unit #(.QUEUE_DEPTH(QDEPTH), .MAP_ENTRIES(MDEPTH)) dut (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_trans_id, .req_log_idx,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_release_valid, .rsp_release_index
   );

   always #5 clock = ~clock;

   typedef struct packed {
      logic [2:0]  status;
      logic        rel_valid;
      logic [63:0] rel_index;
   } watermark_type;

   // model state
   logic [63:0] wm_idx[QDEPTH];
   logic        wm_inact[QDEPTH];
   int          wm_head, wm_count;
   logic [63:0] tx_id[MDEPTH];
   logic [63:0] tx_start[MDEPTH];
   logic        tx_valid[MDEPTH];

   watermark_type pending_wm[$];
   int mismatches = 0, responses = 0, sent = 0, cycles = 0;
   int stall_pct = 30;
   logic [63:0] next_idx;

   function automatic int tx_lookup(logic [63:0] id);
      for (int i = 0; i < MDEPTH; i++) if (tx_valid[i] && tx_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int tx_free();
      for (int i = 0; i < MDEPTH; i++) if (!tx_valid[i]) return i;
      return -1;
   endfunction

   function automatic logic [2:0] append_check(logic [63:0] idx);
      if (wm_count > 0 && idx <= wm_idx[(wm_head + wm_count - 1) % QDEPTH])
         return atwq_pkg::ST_ORDER;
      if (wm_count >= QDEPTH) return atwq_pkg::ST_FULL;
      return atwq_pkg::ST_OK;
   endfunction

   function automatic void append_idx(logic [63:0] idx);
      int s;
      s = (wm_head + wm_count) % QDEPTH;
      wm_idx[s] = idx;
      wm_inact[s] = 1'b0;
      wm_count++;
   endfunction

   function automatic int find_idx(logic [63:0] idx);
      for (int i = 0; i < wm_count; i++)
         if (wm_idx[(wm_head + i) % QDEPTH] == idx) return (wm_head + i) % QDEPTH;
      return -1;
   endfunction

   function automatic void retire_slot(int s);
      wm_inact[s] = 1'b1;
      while (wm_count > 0 && wm_inact[wm_head]) begin
         wm_head = (wm_head + 1) % QDEPTH;
         wm_count--;
      end
   endfunction

   // apply one transaction to the model and return the expected response
   function automatic watermark_type predict_watermark(logic [2:0] act, logic [63:0] id,
                                                      logic [63:0] idx);
      watermark_type r;
      int m, s;
      r.status = atwq_pkg::ST_OK;
      case (act)
         atwq_pkg::ACT_ACTIVATE_TX: begin
            if (tx_lookup(id) >= 0) r.status = atwq_pkg::ST_DUP;
            else begin
               r.status = append_check(idx);
               if (r.status == atwq_pkg::ST_OK) begin
                  m = tx_free();
                  if (m < 0) r.status = atwq_pkg::ST_FULL;
                  else begin
                     tx_valid[m] = 1'b1;
                     tx_id[m] = id;
                     tx_start[m] = idx;
                     append_idx(idx);
                  end
               end
            end
         end
         atwq_pkg::ACT_DEACT_TX: begin
            m = tx_lookup(id);
            if (m < 0) r.status = atwq_pkg::ST_NO_ID;
            else begin
               s = find_idx(tx_start[m]);
               if (s < 0) r.status = atwq_pkg::ST_NO_IDX;
               else begin
                  retire_slot(s);
                  tx_valid[m] = 1'b0;
               end
            end
         end
         atwq_pkg::ACT_ACTIVATE_IDX: begin
            r.status = append_check(idx);
            if (r.status == atwq_pkg::ST_OK) append_idx(idx);
         end
         atwq_pkg::ACT_DEACT_IDX: begin
            s = find_idx(idx);
            if (s < 0) r.status = atwq_pkg::ST_NO_IDX;
            else retire_slot(s);
         end
         atwq_pkg::ACT_CLEAR: begin
            for (int i = 0; i < MDEPTH; i++) tx_valid[i] = 1'b0;
            wm_head = 0;
            wm_count = 0;
         end
         default: ;
      endcase
      r.rel_valid = (wm_count > 0);
      r.rel_index = '0;
      if (wm_count > 0 && wm_idx[wm_head] != 0) r.rel_index = wm_idx[wm_head] - 1;
      return r;
   endfunction

   // directed table: expected typed in where obvious, else predicted
   typedef struct {
      logic [2:0]    act;
      logic [63:0]   id;
      logic [63:0]   idx;
      logic          typed;
      watermark_type wm;
   } vector_type;

   localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;
   vector_type vectors[] = '{
      '{atwq_pkg::ACT_DEACT_TX,     64'd7, 64'd0, 1'b1, '{atwq_pkg::ST_NO_ID, 1'b0, 64'd0}},
      '{atwq_pkg::ACT_DEACT_IDX,    64'd0, 64'd5, 1'b1, '{atwq_pkg::ST_NO_IDX, 1'b0, 64'd0}},
      '{3'd5,                       64'd0, 64'd0, 1'b1, '{atwq_pkg::ST_OK, 1'b0, 64'd0}},
      '{3'd7,                       MAXV,  MAXV,  1'b1, '{atwq_pkg::ST_OK, 1'b0, 64'd0}},
      '{atwq_pkg::ACT_ACTIVATE_TX,  64'd0, 64'd0, 1'b1, '{atwq_pkg::ST_OK, 1'b1, 64'd0}},
      '{atwq_pkg::ACT_ACTIVATE_TX,  64'd0, 64'd9, 1'b1, '{atwq_pkg::ST_DUP, 1'b1, 64'd0}},
      '{atwq_pkg::ACT_ACTIVATE_IDX, 64'd0, 64'd0, 1'b1, '{atwq_pkg::ST_ORDER, 1'b1, 64'd0}},
      '{atwq_pkg::ACT_ACTIVATE_IDX, 64'd0, 64'd5, 1'b0, '0},
      '{atwq_pkg::ACT_ACTIVATE_TX,  MAXV,  64'd9, 1'b0, '0},
      '{atwq_pkg::ACT_DEACT_IDX,    64'd0, 64'd5, 1'b0, '0},
      '{atwq_pkg::ACT_DEACT_IDX,    64'd0, 64'd5, 1'b0, '0},
      '{atwq_pkg::ACT_DEACT_TX,     64'd0, 64'd0, 1'b0, '0},
      '{atwq_pkg::ACT_DEACT_TX,     MAXV,  64'd0, 1'b0, '0},
      '{atwq_pkg::ACT_ACTIVATE_TX,  64'd3, 64'd20, 1'b0, '0},
      '{atwq_pkg::ACT_DEACT_IDX,    64'd0, 64'd20, 1'b0, '0},
      '{atwq_pkg::ACT_DEACT_TX,     64'd3, 64'd0, 1'b1, '{atwq_pkg::ST_NO_IDX, 1'b0, 64'd0}},
      '{atwq_pkg::ACT_ACTIVATE_IDX, 64'd0, MAXV,  1'b1, '{atwq_pkg::ST_OK, 1'b1, MAXV - 1}},
      '{atwq_pkg::ACT_ACTIVATE_IDX, 64'd0, MAXV,  1'b1, '{atwq_pkg::ST_ORDER, 1'b1, MAXV - 1}},
      '{atwq_pkg::ACT_CLEAR,        64'd0, 64'd0, 1'b1, '{atwq_pkg::ST_OK, 1'b0, 64'd0}},
      '{atwq_pkg::ACT_DEACT_TX,     64'd3, 64'd0, 1'b1, '{atwq_pkg::ST_NO_ID, 1'b0, 64'd0}}
   };

   // push one transaction: hold valid until accepted; valid stays up into the
   // next call, which either drops it for an idle gap or loads the next payload
   task automatic send_txn(logic [2:0] act, logic [63:0] id, logic [63:0] idx,
                           logic typed, watermark_type wm);
      watermark_type p;
      while ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_trans_id <= id;
      req_log_idx <= idx;
      do @(posedge clock); while (!req_ready);
      p = predict_watermark(act, id, idx);
      pending_wm.push_back(typed ? wm : p);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random();
      int r;
      logic [63:0] id;
      logic [63:0] idx;
      logic [2:0] act;
      r = $urandom_range(99);
      id = {60'd0, 4'($urandom_range(15))};
      if ($urandom_range(9) == 0) id = {$urandom, $urandom};
      idx = next_idx;
      if (r < 30) begin
         act = atwq_pkg::ACT_ACTIVATE_TX;
         next_idx = next_idx + $urandom_range(1, 4);
      end else if (r < 45) begin
         act = atwq_pkg::ACT_ACTIVATE_IDX;
         next_idx = next_idx + $urandom_range(1, 4);
      end else if (r < 65) act = atwq_pkg::ACT_DEACT_TX;
      else if (r < 88) begin
         act = atwq_pkg::ACT_DEACT_IDX;
         if (wm_count > 0) idx = wm_idx[(wm_head + $urandom_range(wm_count - 1)) % QDEPTH];
         else idx = {$urandom, $urandom};
      end else if (r < 90) begin
         act = atwq_pkg::ACT_CLEAR;
         next_idx = {$urandom, $urandom} >> $urandom_range(63);
      end else if (r < 94) begin
         act = 3'($urandom_range(5, 7));
         idx = {$urandom, $urandom};
      end else begin
         // noise: random index, usually out of order
         act = $urandom_range(1) ? atwq_pkg::ACT_ACTIVATE_IDX : atwq_pkg::ACT_ACTIVATE_TX;
         idx = {$urandom, $urandom};
      end
      if (next_idx > 64'hFFFF_FFFF_FFFF_FF00) next_idx = 64'd1;
      send_txn(act, id, idx, 1'b0, '0);
   endtask

   // response side: random backpressure, compare with oldest expectation
   always @(posedge clock) begin
      watermark_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         responses++;
         if (pending_wm.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response status %0d", rsp_status);
         end else begin
            e = pending_wm[0];
            pending_wm.delete(0);
            if (rsp_status !== e.status || rsp_release_valid !== e.rel_valid ||
                rsp_release_index !== e.rel_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d rv=%0b ri=%h got st=%0d rv=%0b ri=%h",
                           e.status, e.rel_valid, e.rel_index,
                           rsp_status, rsp_release_valid, rsp_release_index);
            end
         end
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      wm_head = 0;
      wm_count = 0;
      for (int i = 0; i < MDEPTH; i++) tx_valid[i] = 1'b0;
      next_idx = 64'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (vectors[i])
         send_txn(vectors[i].act, vectors[i].id, vectors[i].idx, vectors[i].typed,
                  vectors[i].wm);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a quiet stretch with no idling on either side
         stall_pct = (n >= 600 && n < 900) ? 0 : 30;
         if (n == 300 || n == 1200) begin
            // hold off until the block has drained
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_wm.size() != 0) @(negedge clock);
         end
         send_random();
      end
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_wm.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("covered %0d transactions (directed table and random), %0d responses",
               sent, responses);
      if (mismatches == 0 && pending_wm.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+src
src/atwq_pkg.sv
src/active_transaction_watermark_queue_unit.sv
src/atwq_checker.sv
sim/active_transaction_watermark_queue_unit_tb.sv
